// ===== design/lss_pkg.sv =====
// Shared types, codes and helpers for the line search step sequencer.
`default_nettype none
package lss_pkg;

  localparam int unsigned AddrW = 3;
  localparam logic [5:0] MaxShrinkRst = 6'd16;
  localparam logic OpStart = 1'b0;
  localparam logic OpObj   = 1'b1;
  localparam logic signed [65:0] SatHi = 66'sd2147483647;
  localparam logic signed [65:0] SatLo = -66'sd2147483648;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PROBE, PH_GROW, PH_SHRINK, PH_VERTEX
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EVAL = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV1, S_DIV2, S_CURV, S_MUL, S_DIV3, S_EMIT_MID, S_EMIT_VTX
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_D1, DIV_D2, DIV_Q
  } div_sel_e;

  typedef struct packed {
    logic     step;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_d1;
    logic     cap_d2;
    logic     load_prod;
    logic     cap_vtx;
    logic     emit_mid;
    logic     emit_vtx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bracket;
    logic vtx_ok;
    logic curv_zero;
    logic div_done;
    logic slot_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7fffffff;
    end else if (v < SatLo) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lss_in_if.sv =====
// Input channel: start or objective beats.
`default_nettype none
interface lss_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [30:0] first_step;
  logic signed [31:0] start_value;
  logic signed [31:0] objective;
  modport source(output valid, op, first_step, start_value, objective, input ready);
  modport sink(input valid, op, first_step, start_value, objective, output ready);
endinterface
`default_nettype wire

// ===== design/lss_out_if.sv =====
// Output channel: request, done or failure beats.
`default_nettype none
interface lss_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] step;
  logic signed [31:0] best_value;
  modport source(output valid, kind, step, best_value, input ready);
  modport sink(input valid, kind, step, best_value, output ready);
endinterface
`default_nettype wire

// ===== design/lss_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none
module lss_div
  import lss_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [34:0] den_i,
  output logic                    done_o,
  output logic signed [63:0]      quo_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q, dmag_q;
  logic [63:0] acc_q;
  logic [63:0] nmag;
  logic [34:0] dfull;
  logic [34:0] trial, diff;
  logic        qbit;

  assign nmag  = num_i[63] ? 64'(-num_i) : 64'(num_i);
  assign dfull = den_i[34] ? 35'(-den_i) : 35'(den_i);
  assign trial = {rem_q, acc_q[63]};
  assign diff  = trial - {1'b0, dmag_q};
  assign qbit  = (trial >= {1'b0, dmag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= nmag;
      rem_q  <= '0;
      dmag_q <= dfull[33:0];
      neg_q  <= num_i[63] ^ den_i[34];
    end else if (busy_q) begin
      acc_q <= {acc_q[62:0], qbit};
      rem_q <= qbit ? diff[33:0] : trial[33:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(acc_q) : $signed(acc_q);

  ap_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ===== design/lss_dp.sv =====
// Datapath: bracket registers, per-beat update, vertex arithmetic and output register.
`default_nettype none
module lss_dp
  import lss_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic               op_i,
  input  wire logic        [30:0] first_step_i,
  input  wire logic signed [31:0] start_value_i,
  input  wire logic signed [31:0] objective_i,
  input  wire logic               cfg_we_i,
  input  wire logic        [5:0]  cfg_wdata_i,
  output logic             [5:0]  max_shrink_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic             [1:0]  kind_o,
  output logic signed      [31:0] step_o,
  output logic signed      [31:0] best_value_o
);

  phase_e             phase_q, phase_d;
  logic signed [31:0] ls_q, ms_q, hs_q, lv_q, mv_q, hv_q, vtx_q;
  logic signed [31:0] ls_d, ms_d, hs_d, lv_d, mv_d, hv_d;
  logic        [5:0]  retry_q, retry_d, max_shrink_q;
  logic               interp_q, interp_d;
  logic signed [31:0] d1_q, d2_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q;
  logic        [1:0]  out_kind_q;
  logic signed [31:0] out_step_q, out_val_q;

  logic               r_load, brk;
  kind_e              r_kind;
  logic signed [31:0] r_step, r_val;

  logic signed [32:0] dh02, dh0m, curv, half;
  logic signed [31:0] dh2m;
  logic signed [63:0] num, quo, prod_d;
  logic signed [34:0] den;
  logic               div_done;
  logic signed [65:0] vtx_full;

  always_comb begin
    logic [5:0]         inc;
    logic signed [31:0] g;
    logic               grow;
    inc      = retry_q + 6'd1;
    g        = objective_i;
    grow     = 1'b0;
    phase_d  = phase_q;
    ls_d = ls_q; ms_d = ms_q; hs_d = hs_q;
    lv_d = lv_q; mv_d = mv_q; hv_d = hv_q;
    retry_d  = retry_q;
    interp_d = interp_q;
    r_load   = 1'b1;
    r_kind   = KIND_FAIL;
    r_step   = '0;
    r_val    = '0;
    brk      = 1'b0;
    if (op_i == OpStart) begin
      ls_d = '0; lv_d = start_value_i;
      hs_d = {1'b0, first_step_i};
      ms_d = '0; mv_d = '0; hv_d = '0;
      retry_d  = '0;
      interp_d = 1'b1;
      phase_d  = PH_PROBE;
      r_kind   = KIND_EVAL;
      r_step   = {1'b0, first_step_i};
    end else begin
      unique case (phase_q)
        PH_PROBE: begin
          if (objective_i < 0) begin
            retry_d = inc;
            if (inc == 6'd0 || inc > max_shrink_q) begin
              phase_d = PH_IDLE;
            end else begin
              hs_d   = hs_q >>> 1;
              r_kind = KIND_EVAL;
              r_step = hs_q >>> 1;
            end
          end else begin
            hv_d = objective_i;
            if (objective_i < lv_q) begin
              ms_d = hs_q;
              mv_d = objective_i;
              grow = 1'b1;
            end else begin
              retry_d = '0;
              ms_d    = hs_q >>> 1;
              phase_d = PH_SHRINK;
              r_kind  = KIND_EVAL;
              r_step  = hs_q >>> 1;
            end
          end
        end
        PH_GROW: begin
          if (objective_i < 0) begin
            g        = sat32({{32{mv_q[31]}}, mv_q, 2'b00});
            interp_d = 1'b0;
          end
          hv_d = g;
          if (g < mv_q) begin
            ls_d = ms_q; lv_d = mv_q;
            ms_d = hs_q; mv_d = g;
            grow = 1'b1;
          end else begin
            brk = 1'b1;
          end
        end
        PH_SHRINK: begin
          mv_d = objective_i;
          if (objective_i > lv_q || objective_i < 0) begin
            retry_d = inc;
            if (inc == 6'd0 || inc > max_shrink_q) begin
              phase_d = PH_IDLE;
            end else begin
              hs_d   = ms_q;
              hv_d   = objective_i;
              ms_d   = ms_q >>> 1;
              r_kind = KIND_EVAL;
              r_step = ms_q >>> 1;
            end
          end else begin
            brk = 1'b1;
          end
        end
        PH_VERTEX: begin
          phase_d = PH_IDLE;
          r_kind  = KIND_DONE;
          if (objective_i >= 0 && objective_i <= mv_q) begin
            r_step = vtx_q;
            r_val  = objective_i;
          end else begin
            r_step = ms_q;
            r_val  = mv_q;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    if (grow) begin
      if (hs_q[30]) begin
        interp_d = 1'b0;
        phase_d  = PH_IDLE;
        r_kind   = KIND_DONE;
        r_step   = ms_d;
        r_val    = mv_d;
      end else begin
        hs_d    = hs_q <<< 1;
        phase_d = PH_GROW;
        r_kind  = KIND_EVAL;
        r_step  = hs_q <<< 1;
      end
    end
    if (brk) begin
      phase_d = PH_IDLE;
      r_load  = 1'b0;
    end
  end

  assign dh02   = {ls_q[31], ls_q} - {hs_q[31], hs_q};
  assign dh0m   = {ls_q[31], ls_q} - {ms_q[31], ms_q};
  assign dh2m   = hs_q - ms_q;
  assign curv   = {d1_q[31], d1_q} - {d2_q[31], d2_q};
  assign half   = ({ls_q[31], ls_q} + {hs_q[31], hs_q}) >>> 1;
  assign prod_d = d1_q * dh2m;

  always_comb begin
    logic signed [32:0] dv;
    dv = {lv_q[31], lv_q} - {hv_q[31], hv_q};
    num = {{15{dv[32]}}, dv, 16'b0};
    den = {{2{dh02[32]}}, dh02};
    case (cmd_i.div_sel)
      DIV_D2: begin
        dv  = {lv_q[31], lv_q} - {mv_q[31], mv_q};
        num = {{15{dv[32]}}, dv, 16'b0};
        den = {{2{dh0m[32]}}, dh0m};
      end
      DIV_Q: begin
        num = prod_q;
        den = {curv[32], curv, 1'b0};
      end
      default: ;
    endcase
  end

  lss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign vtx_full = {{33{half[32]}}, half} - {{2{quo[63]}}, quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      ls_q <= '0; ms_q <= '0; hs_q <= '0;
      lv_q <= '0; mv_q <= '0; hv_q <= '0;
      vtx_q        <= '0;
      retry_q      <= '0;
      interp_q     <= 1'b1;
      max_shrink_q <= MaxShrinkRst;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) max_shrink_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.step) begin
        phase_q <= phase_d;
        ls_q <= ls_d; ms_q <= ms_d; hs_q <= hs_d;
        lv_q <= lv_d; mv_q <= mv_d; hv_q <= hv_d;
        retry_q  <= retry_d;
        interp_q <= interp_d;
        if (op_i == OpStart) vtx_q <= '0;
        if (r_load) out_valid_q <= 1'b1;
      end
      if (cmd_i.cap_vtx) vtx_q <= sat32(vtx_full);
      if (cmd_i.emit_vtx) begin
        phase_q     <= PH_VERTEX;
        out_valid_q <= 1'b1;
      end
      if (cmd_i.emit_mid) begin
        phase_q     <= PH_IDLE;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_d1) d1_q <= sat32({{2{quo[63]}}, quo});
    if (cmd_i.cap_d2) d2_q <= sat32({{2{quo[63]}}, quo});
    if (cmd_i.load_prod) prod_q <= prod_d;
    if (cmd_i.step && r_load) begin
      out_kind_q <= r_kind;
      out_step_q <= r_step;
      out_val_q  <= r_val;
    end else if (cmd_i.emit_mid) begin
      out_kind_q <= KIND_DONE;
      out_step_q <= ms_q;
      out_val_q  <= mv_q;
    end else if (cmd_i.emit_vtx) begin
      out_kind_q <= KIND_EVAL;
      out_step_q <= vtx_q;
      out_val_q  <= '0;
    end
  end

  assign stat_o.bracket   = brk;
  assign stat_o.vtx_ok    = interp_q && (dh02 != 0) && (dh0m != 0) && (dh2m != 0);
  assign stat_o.curv_zero = (curv == 0);
  assign stat_o.div_done  = div_done;
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

  assign max_shrink_o = max_shrink_q;
  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign step_o       = out_step_q;
  assign best_value_o = out_val_q;

  ap_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.step && r_load) || cmd_i.emit_mid || cmd_i.emit_vtx)
      |-> (!out_valid_q || out_ready_i)) else $error("output beat overwritten");

  ap_vtx_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_vtx |=> (phase_q == PH_VERTEX && out_kind_q == KIND_EVAL))
    else $error("vertex request without vertex phase");

endmodule
`default_nettype wire

// ===== design/lss_ctrl.sv =====
// Controller: sequences beat acceptance, the three divisions and result emission.
`default_nettype none
module lss_ctrl
  import lss_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output ctrl_cmd_t     cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i && stat_i.slot_free && stat_i.bracket) state_d = S_CHECK;
      S_CHECK:    state_d = stat_i.vtx_ok ? S_DIV1 : S_EMIT_MID;
      S_DIV1:     if (stat_i.div_done) state_d = S_DIV2;
      S_DIV2:     if (stat_i.div_done) state_d = S_CURV;
      S_CURV:     state_d = stat_i.curv_zero ? S_EMIT_MID : S_MUL;
      S_MUL:      state_d = S_DIV3;
      S_DIV3:     if (stat_i.div_done) state_d = S_EMIT_VTX;
      S_EMIT_MID: if (stat_i.slot_free) state_d = S_IDLE;
      S_EMIT_VTX: if (stat_i.slot_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.div_sel = DIV_D1;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.slot_free;
        cmd_o.step = in_valid_i && stat_i.slot_free;
      end
      S_CHECK: cmd_o.div_start = stat_i.vtx_ok;
      S_DIV1: begin
        cmd_o.cap_d1    = stat_i.div_done;
        cmd_o.div_start = stat_i.div_done;
        cmd_o.div_sel   = DIV_D2;
      end
      S_DIV2: cmd_o.cap_d2 = stat_i.div_done;
      S_CURV: cmd_o.load_prod = !stat_i.curv_zero;
      S_MUL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_Q;
      end
      S_DIV3: begin
        cmd_o.div_sel = DIV_Q;
        cmd_o.cap_vtx = stat_i.div_done;
      end
      S_EMIT_MID: cmd_o.emit_mid = stat_i.slot_free;
      S_EMIT_VTX: cmd_o.emit_vtx = stat_i.slot_free;
      default: ;
    endcase
  end

  ap_one_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.step, cmd_o.emit_mid, cmd_o.emit_vtx}))
    else $error("more than one result source");

  ap_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV3 && !stat_i.div_done) |=> state_q == S_DIV3)
    else $error("left final division early");

endmodule
`default_nettype wire

// ===== design/line_search_step_sequencer_unit.sv =====
// Top level of the line search step sequencer: channels, register port and wiring.
// Each input beat yields one output beat. A request beat, a failure or a done beat from
// saturated growth is valid in the cycle after acceptance. A completed bracket first
// passes a check state: without interpolation the middle point is then emitted from the
// emit state. With interpolation, the vertex takes three divisions on one shared radix-2
// divider, plus a multiply stage; a zero curvature stops after the second division. No
// input is taken meanwhile, and each emit waits for a free output register.
// Input is taken only while the output register is empty or being drained.
// max_shrink is written at byte addresses 0 to 3 (paddr[2] low); writes to 4 to 7 are ignored.
`default_nettype none
module line_search_step_sequencer_unit
  import lss_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  lss_in_if.sink                in_i,
  lss_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic       cfg_we;
  logic [5:0] max_shrink;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = {26'b0, max_shrink};

  lss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (in_i.op),
    .first_step_i (in_i.first_step),
    .start_value_i(in_i.start_value),
    .objective_i  (in_i.objective),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[5:0]),
    .max_shrink_o (max_shrink),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .kind_o       (out_o.kind),
    .step_o       (out_o.step),
    .best_value_o (out_o.best_value)
  );

endmodule
`default_nettype wire
